FILE: hdl/spcc_pkg.sv
package spcc_pkg;

    // stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_LIMIT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LOW = 8'd1;

    // field widths
    localparam int POS_W  = 16;
    localparam int TOP_W  = 16;
    localparam int HALF_W = 15;
    localparam int MAG_W  = 17;
    localparam int PROD_W = 32;

    // reset values
    localparam logic [POS_W-1:0]  POS_LIMIT_RESET  = 16'd30000;
    localparam logic [POS_W-1:0]  PERIOD_LOW_RESET = 16'd10;
    localparam logic [TOP_W-1:0]  TOP_RESET        = 16'd3749;
    localparam logic [HALF_W-1:0] HALF_RESET       = 15'd1874;

    // parsed magnitude saturates here
    localparam logic [MAG_W-1:0] MAG_SAT = 17'h10000;

    // request kinds on the input tuser
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;

    typedef enum logic [1:0] {
        RK_NONE   = 2'd0,
        RK_POS    = 2'd1,
        RK_PERIOD = 2'd2
    } report_kind_t;

endpackage

FILE: hdl/spcc_div.sv
module spcc_div
    import spcc_pkg::*;
#(
    parameter int TOP_SCALE   = 3749,
    parameter int PERIOD_FULL = 60000
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [POS_W-1:0]  value,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    localparam int RECIP_W = 48;
    localparam int PART_W  = 24;
    localparam int ACC_W   = 64;

    // value * TOP_SCALE / PERIOD_FULL as (value * RECIP) >> 32 with RECIP
    // rounded up; exact because value * PERIOD_FULL stays below 2**32
    localparam logic [ACC_W-1:0] RECIP_WIDE =
        ((ACC_W'(TOP_SCALE) << 32) + ACC_W'(PERIOD_FULL) - ACC_W'(1)) / ACC_W'(PERIOD_FULL);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

    logic              busy_reg;
    logic              hi_reg;
    logic              done_reg;
    logic [POS_W-1:0]  val_reg;
    logic [ACC_W-1:0]  acc_reg;

    logic [PART_W-1:0]       coef;
    logic [POS_W+PART_W-1:0] partial;

    // one 16 x 24 multiplier, low half of the constant first, then high half
    always_comb begin
        coef    = hi_reg ? RECIP[RECIP_W-1:PART_W] : RECIP[PART_W-1:0];
        partial = {{PART_W{1'b0}}, val_reg} * {{POS_W{1'b0}}, coef};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && hi_reg;
            if (start) begin
                busy_reg <= 1'b1;
                hi_reg   <= 1'b0;
                val_reg  <= value;
            end else if (busy_reg) begin
                if (!hi_reg) begin
                    acc_reg <= {{(ACC_W-POS_W-PART_W){1'b0}}, partial};
                    hi_reg  <= 1'b1;
                end else begin
                    acc_reg  <= acc_reg + {partial, {PART_W{1'b0}}};
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg[ACC_W-1:ACC_W-PROD_W];

endmodule

FILE: hdl/stepper_position_command_controller.sv
// stepper position controller with a serial command line
//
// s_ channel: one item per received serial byte (s_tuser = 0, byte in
// s_tdata) or per step timer tick (s_tuser = 1). m_ channel: exactly one
// result item per input item, showing the state after that item, with the
// report kind in m_tuser. cfg_ channel writes the position limit (index 0)
// and the lowest accepted period value (index 1); cfg_ready is always high.
//
// a tick or any byte other than a carriage return goes straight to S_DONE,
// which loads the output register once it is free and returns to S_IDLE
// to take the next item. a carriage return walks the line buffer with an
// S_READ and an S_EVAL step per character read (single read port with
// registered data): the command letter, then the argument, leading blanks,
// an optional sign and the digits. a period command in range adds the two
// step reciprocal multiply. s_tready is low until the state is S_IDLE again.
//
// reset: limits 30000 and 10, positions 0, top 3749, half 1874, step
// output enabled. the line buffer is not cleared. if the receiver stalls,
// the result holds on m_ and one more item can be taken and worked on.
module stepper_position_command_controller
    import spcc_pkg::*;
#(
    parameter int BUF_DEPTH   = 32,
    parameter int TOP_SCALE   = 3749,
    parameter int PERIOD_FULL = 60000
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // rx_byte[7:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,   // req_type[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // target_position[15:0], current_position[31:16], period_top[47:32],
    // period_half[62:48], step_enable[63], direction[64], zeros[71:65]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser,   // report_kind[1:0]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int IW = $clog2(BUF_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DSTART,
        S_DIV,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_ARG,
        PH_WS,
        PH_DIG
    } phase_t;

    state_t       state_reg;
    phase_t       phase_reg;
    report_kind_t kind_reg;

    logic [POS_W-1:0]  pos_limit_reg;
    logic [POS_W-1:0]  period_low_reg;
    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     ch_idx_reg;
    logic [POS_W-1:0]  target_reg;
    logic [POS_W-1:0]  position_reg;
    logic [TOP_W-1:0]  top_reg;
    logic [HALF_W-1:0] half_reg;
    logic              dir_reg;
    logic              enable_reg;
    logic              cmd_t_reg;
    logic              neg_reg;
    logic              oob_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic [7:0] line_mem [BUF_DEPTH];
    logic [7:0] rdata_reg;

    logic              s_acc;
    logic              buf_wr;
    logic [7:0]        ch;
    logic [MAG_W+2:0]  mag_step;
    logic [MAG_W-1:0]  mag_sat;
    logic              num_ok;
    logic              div_start;
    logic              div_done;
    logic [PROD_W-1:0] div_q;
    logic [TOP_W-1:0]  top_sat;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign buf_wr    = s_acc && (s_tuser[0] == REQ_BYTE) && (s_tdata != CH_COLON)
                       && (s_tdata != CH_CR) && (idx_reg < IW'(BUF_DEPTH));
    assign div_start = (state_reg == S_DSTART);

    // line buffer, one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (buf_wr) begin
            line_mem[idx_reg[AW-1:0]] <= s_tdata;
        end
        rdata_reg <= line_mem[ch_idx_reg[AW-1:0]];
    end

    always_comb begin
        // characters past the line end read as a terminator
        ch       = oob_reg ? CH_NUL : rdata_reg;
        mag_step = ({3'b000, mag_reg} << 3) + ({3'b000, mag_reg} << 1)
                   + {{(MAG_W-1){1'b0}}, ch[3:0]};
        mag_sat  = (mag_step > (MAG_W+3)'(MAG_SAT)) ? MAG_SAT : mag_step[MAG_W-1:0];
        num_ok   = !(neg_reg && (mag_reg != '0));
        top_sat  = (div_q[PROD_W-1:TOP_W] != '0) ? '1 : div_q[TOP_W-1:0];
    end

    spcc_div #(
        .TOP_SCALE   (TOP_SCALE),
        .PERIOD_FULL (PERIOD_FULL)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .value    (mag_reg[POS_W-1:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pos_limit_reg  <= POS_LIMIT_RESET;
            period_low_reg <= PERIOD_LOW_RESET;
            idx_reg        <= '0;
            target_reg     <= '0;
            position_reg   <= '0;
            top_reg        <= TOP_RESET;
            half_reg       <= HALF_RESET;
            dir_reg        <= 1'b0;
            enable_reg     <= 1'b1;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_POS_LIMIT:  pos_limit_reg  <= cfg_data;
                    CFG_PERIOD_LOW: period_low_reg <= cfg_data;
                    default: ;
                endcase
            end

            // in S_DONE the output register is handled below
            if (m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        kind_reg <= RK_NONE;
                        if (s_tuser[0] == REQ_TICK) begin
                            if (target_reg > position_reg) begin
                                dir_reg      <= 1'b1;
                                enable_reg   <= 1'b1;
                                position_reg <= position_reg + 1'b1;
                            end else if (target_reg < position_reg) begin
                                dir_reg      <= 1'b0;
                                enable_reg   <= 1'b1;
                                position_reg <= position_reg - 1'b1;
                            end else begin
                                enable_reg <= 1'b0;
                            end
                            state_reg <= S_DONE;
                        end else if (s_tdata == CH_COLON) begin
                            idx_reg   <= '0;
                            state_reg <= S_DONE;
                        end else if (s_tdata == CH_CR) begin
                            ch_idx_reg <= '0;
                            phase_reg  <= PH_FIRST;
                            state_reg  <= S_READ;
                        end else begin
                            if (idx_reg < IW'(BUF_DEPTH)) begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                            state_reg <= S_DONE;
                        end
                    end
                end

                S_READ: begin
                    oob_reg   <= (ch_idx_reg >= idx_reg);
                    state_reg <= S_EVAL;
                end

                S_EVAL: begin
                    case (phase_reg)
                        PH_FIRST: begin
                            if (ch inside {CH_P, CH_T}) begin
                                cmd_t_reg  <= (ch == CH_T);
                                ch_idx_reg <= IW'(1);
                                phase_reg  <= PH_ARG;
                                state_reg  <= S_READ;
                            end else begin
                                kind_reg  <= RK_NONE;
                                state_reg <= S_DONE;
                            end
                        end
                        PH_ARG: begin
                            if (ch == CH_NUL) begin
                                kind_reg  <= cmd_t_reg ? RK_PERIOD : RK_POS;
                                state_reg <= S_DONE;
                            end else begin
                                mag_reg   <= '0;
                                neg_reg   <= 1'b0;
                                phase_reg <= PH_WS;
                                state_reg <= S_READ;
                            end
                        end
                        PH_WS: begin
                            if (ch inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
                                ch_idx_reg <= ch_idx_reg + 1'b1;
                            end else if (ch inside {CH_PLUS, CH_MINUS}) begin
                                neg_reg    <= (ch == CH_MINUS);
                                ch_idx_reg <= ch_idx_reg + 1'b1;
                                phase_reg  <= PH_DIG;
                            end else begin
                                // same character again as a digit
                                phase_reg <= PH_DIG;
                            end
                            state_reg <= S_READ;
                        end
                        PH_DIG: begin
                            if (ch inside {[CH_ZERO:CH_NINE]}) begin
                                mag_reg    <= mag_sat;
                                ch_idx_reg <= ch_idx_reg + 1'b1;
                                state_reg  <= S_READ;
                            end else if (!cmd_t_reg) begin
                                if (num_ok && (mag_reg <= {1'b0, pos_limit_reg})) begin
                                    target_reg <= mag_reg[POS_W-1:0];
                                end
                                kind_reg  <= RK_POS;
                                state_reg <= S_DONE;
                            end else begin
                                kind_reg <= RK_PERIOD;
                                if (num_ok && (mag_reg >= {1'b0, period_low_reg})
                                        && (mag_reg <= MAG_W'(PERIOD_FULL))) begin
                                    state_reg <= S_DSTART;
                                end else begin
                                    state_reg <= S_DONE;
                                end
                            end
                        end
                        default: state_reg <= S_DONE;
                    endcase
                end

                S_DSTART: begin
                    state_reg <= S_DIV;
                end

                S_DIV: begin
                    if (div_done) begin
                        top_reg   <= top_sat;
                        half_reg  <= top_sat[TOP_W-1:1];
                        state_reg <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {7'b0, dir_reg, enable_reg, half_reg, top_reg,
                                         position_reg, target_reg};
                        m_tuser_reg  <= kind_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: hdl/spcc_chk.sv
module spcc_chk
    import spcc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item at a time: ready drops after each accepted item
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    a_kind_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("bad report kind");

    // half period always tracks the top
    a_half_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[62:48] == m_tdata[47:33])
        else $error("half period does not match top");

    // zero fill above the fields
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:65] == 7'd0)
        else $error("pad bits not zero");

endmodule

bind stepper_position_command_controller spcc_chk u_spcc_chk (.*);
